>>> src/ntcb_pkg.sv
// Shared constants and types for the NTC beta temperature converter.
`default_nettype none
package ntcb_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int RES_W = 20;
  localparam int BETA_W = 14;
  localparam int TEMP_W = 18;
  localparam int LOG_FRAC = 28;
  localparam int MANT_W = 31;
  localparam int Q_BITS = 17;

  localparam logic [27:0] LN2_Q28 = 28'd186065279;
  localparam logic [14:0] T25_CENTI = 15'd29815;
  localparam logic [21:0] NUM_SCALE = 22'd2981500;
  localparam logic [6:0] CENTI_PER_UNIT = 7'd100;
  localparam logic [16:0] Q_MAX = 17'd127215;
  localparam logic signed [TEMP_W-1:0] MAX_CENTI = 18'sd99900;
  localparam logic signed [TEMP_W-1:0] MIN_CENTI = -18'sd27315;
  localparam logic [TEMP_W-1:0] ZERO_C_CENTI = 18'd27315;

  localparam logic [RES_W-1:0] SERIES_RST = 20'd10000;
  localparam logic [RES_W-1:0] NOMINAL_RST = 20'd10000;
  localparam logic [BETA_W-1:0] BETA_RST = 14'd3950;

  localparam logic [1:0] CFG_SERIES = 2'd0;
  localparam logic [1:0] CFG_NOMINAL = 2'd1;
  localparam logic [1:0] CFG_BETA = 2'd2;

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic       v;
    logic [1:0] status;
  } side_t;

endpackage
`default_nettype wire

>>> src/ntcb_log2.sv
// Pipelined base-2 logarithm in Q28 by normalization and repeated squaring.
`default_nettype none
module ntcb_log2 #(
  parameter int XW = 32
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [XW-1:0]                     x,
  output logic [$clog2(XW)+ntcb_pkg::LOG_FRAC-1:0] log_q
);

  localparam int KW = $clog2(XW);
  localparam int MW = ntcb_pkg::MANT_W;
  localparam int NS = ntcb_pkg::LOG_FRAC;

  logic [XW-1:0]    x_eff;
  logic [KW-1:0]    k_nxt;
  logic [XW+MW-2:0] mwide;

  logic [KW-1:0]  k_r    [0:NS];
  logic [MW-1:0]  m_r    [0:NS];
  logic [NS-1:0]  frac_r [0:NS];

  always_comb begin
    x_eff = (x == '0) ? XW'(1) : x;
    k_nxt = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_eff[i]) begin
        k_nxt = KW'(i);
      end
    end
    mwide = {x_eff, {(MW-1){1'b0}}} >> k_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r[0]    <= k_nxt;
      m_r[0]    <= mwide[MW-1:0];
      frac_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     t;
    always_comb begin
      sq = {{MW{1'b0}}, m_r[j-1]} * {{MW{1'b0}}, m_r[j-1]};
      t  = sq[2*MW-1:MW-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        k_r[j]    <= k_r[j-1];
        m_r[j]    <= t[MW] ? t[MW:1] : t[MW-1:0];
        frac_r[j] <= {frac_r[j-1][NS-2:0], t[MW]};
      end
    end
  end

  assign log_q = {k_r[NS], frac_r[NS]};

endmodule
`default_nettype wire

>>> src/ntcb_div.sv
// Pipelined restoring divider giving a bounded quotient and an overflow flag.
`default_nettype none
module ntcb_div #(
  parameter int NW = 65,
  parameter int DW = 50
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [NW-1:0]                 n,
  input  wire logic [DW-1:0]                 d,
  output logic [ntcb_pkg::Q_BITS-1:0]        q,
  output logic                               ovf
);

  localparam int QB = ntcb_pkg::Q_BITS;
  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [NW-1:0] rem_r [0:QB];
  logic [DW-1:0] d_r   [0:QB];
  logic [QB-1:0] q_r   [0:QB];
  logic          ovf_r [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n;
      d_r[0]   <= d;
      q_r[0]   <= '0;
      ovf_r[0] <= CW'(n) >= (CW'(d) << QB);
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff;
    logic          ge;
    always_comb begin
      dsh  = CW'(d_r[j-1]) << (QB - j);
      ge   = CW'(rem_r[j-1]) >= dsh;
      diff = CW'(rem_r[j-1]) - dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? diff[NW-1:0] : rem_r[j-1];
        d_r[j]   <= d_r[j-1];
        q_r[j]   <= {q_r[j-1][QB-2:0], ge};
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign q   = q_r[QB];
  assign ovf = ovf_r[QB];

endmodule
`default_nettype wire

>>> src/ntc_beta_temperature_converter.sv
// Top level: NTC divider reading to temperature in hundredths of a degree Celsius.
// An accepted request passes through 53 register stages up to the output register.
// One request per cycle is taken while the output is not stalled; two parallel 28-stage
// squaring log units and a 17-stage restoring divider set the depth.
// A stalled full output register freezes the whole pipeline, so nothing is lost.
// Synchronous active-low reset empties the pipeline and restores the register defaults.
`default_nettype none
module ntc_beta_temperature_converter #(
  parameter int ADC_BITS = ntcb_pkg::ADC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ADC_BITS-1:0]               in_adc_sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [ntcb_pkg::TEMP_W-1:0]     out_temperature_centi,
  output logic [1:0]                             out_status,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [ntcb_pkg::RES_W-1:0]        cfg_wdata
);

  localparam int RW = ntcb_pkg::RES_W;
  localparam int BW = ntcb_pkg::BETA_W;
  localparam int FR = ntcb_pkg::LOG_FRAC;
  localparam int PW = RW + ADC_BITS;
  localparam int KW = $clog2(PW);
  localparam int LW = KW + FR;
  localparam int PTW = 21 + FR;
  localparam int DW = ((15 + LW > PTW) ? 15 + LW : PTW) + 2;
  localparam int NUMW = 36 + FR;
  localparam int NW = ((NUMW > DW - 1) ? NUMW : DW - 1) + 1;
  localparam int LOG_LAT = FR + 1;
  localparam int DIV_LAT = ntcb_pkg::Q_BITS + 1;
  localparam int SL = 4 + LOG_LAT + 1 + DIV_LAT;
  localparam int QB = ntcb_pkg::Q_BITS;
  localparam int TW = ntcb_pkg::TEMP_W;

  logic [RW-1:0] series_ohm_r;
  logic [RW-1:0] nominal_r;
  logic [BW-1:0] beta_r;
  logic [RW-1:0] s_eff;
  logic [RW-1:0] r25_eff;
  logic [BW-1:0] b_eff;

  logic en;
  logic out_valid_r;
  logic signed [TW-1:0] temp_r;
  logic [1:0] status_r;

  ntcb_pkg::side_t side_r [0:SL-1];
  ntcb_pkg::side_t side_nxt;

  logic [ADC_BITS-1:0] fs;
  logic [PW-1:0] pa_r;
  logic [PW-1:0] pb_r;
  logic [LW-1:0] la;
  logic [LW-1:0] lb;
  logic          neg_r;
  logic [LW-1:0] dmag_r;
  logic [LW+28:0] lprod;
  logic          lneg_r;
  logic [LW-1:0] lmag_r;
  logic [DW-1:0] pterm;
  logic [DW-1:0] tterm;
  logic [DW-1:0] den_r;
  logic [NW-1:0] num_r;
  logic [NW-1:0] n_r;
  logic [DW-2:0] d_r;
  logic          dz_r [0:DIV_LAT];
  logic          dn_r [0:DIV_LAT];
  logic [QB-1:0] q;
  logic          ovf;
  logic signed [TW-1:0] temp_nxt;

  assign s_eff   = (series_ohm_r == '0) ? RW'(1) : series_ohm_r;
  assign r25_eff = (nominal_r == '0) ? RW'(1) : nominal_r;
  assign b_eff   = (beta_r == '0) ? BW'(1) : beta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_ohm_r <= ntcb_pkg::SERIES_RST;
      nominal_r    <= ntcb_pkg::NOMINAL_RST;
      beta_r       <= ntcb_pkg::BETA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ntcb_pkg::CFG_SERIES:  series_ohm_r <= cfg_wdata;
        ntcb_pkg::CFG_NOMINAL: nominal_r    <= cfg_wdata;
        ntcb_pkg::CFG_BETA:    beta_r       <= cfg_wdata[BW-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = out_valid_r && out_stall;
  assign fs       = '1;

  always_comb begin
    side_nxt.v = in_valid;
    if (in_adc_sample == '0) begin
      side_nxt.status = ntcb_pkg::ST_ZERO;
    end else if (in_adc_sample == fs) begin
      side_nxt.status = ntcb_pkg::ST_FULL;
    end else begin
      side_nxt.status = ntcb_pkg::ST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SL; i++) begin
        side_r[i] <= '0;
      end
    end else if (en) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < SL; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= PW'(s_eff) * PW'(in_adc_sample);
      pb_r <= PW'(r25_eff) * PW'(fs - in_adc_sample);
    end
  end

  ntcb_log2 #(.XW(PW)) u_log_a (.clk(clk), .en(en), .x(pa_r), .log_q(la));
  ntcb_log2 #(.XW(PW)) u_log_b (.clk(clk), .en(en), .x(pb_r), .log_q(lb));

  assign lprod = (LW+29)'(dmag_r) * (LW+29)'(ntcb_pkg::LN2_Q28) + ((LW+29)'(1) << (FR - 1));
  assign pterm = DW'(21'(b_eff) * 21'(ntcb_pkg::CENTI_PER_UNIT)) << FR;
  assign tterm = DW'(lmag_r) * DW'(ntcb_pkg::T25_CENTI);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= lb > la;
      dmag_r <= (lb > la) ? lb - la : la - lb;
      lneg_r <= neg_r;
      lmag_r <= lprod[LW+FR-1:FR];
      den_r  <= lneg_r ? pterm - tterm : pterm + tterm;
      num_r  <= NW'(36'(b_eff) * 36'(ntcb_pkg::NUM_SCALE)) << FR;
      n_r    <= num_r + NW'(den_r[DW-1:1]);
      d_r    <= den_r[DW-2:0];
      dz_r[0] <= den_r == '0;
      dn_r[0] <= den_r[DW-1];
      for (int i = 1; i <= DIV_LAT; i++) begin
        dz_r[i] <= dz_r[i-1];
        dn_r[i] <= dn_r[i-1];
      end
    end
  end

  ntcb_div #(.NW(NW), .DW(DW-1)) u_div (
    .clk(clk), .en(en), .n(n_r), .d(d_r), .q(q), .ovf(ovf)
  );

  always_comb begin
    if (side_r[SL-1].status == ntcb_pkg::ST_ZERO) begin
      temp_nxt = ntcb_pkg::MIN_CENTI;
    end else if (side_r[SL-1].status == ntcb_pkg::ST_FULL) begin
      temp_nxt = ntcb_pkg::MAX_CENTI;
    end else if (dz_r[DIV_LAT]) begin
      temp_nxt = ntcb_pkg::MAX_CENTI;
    end else if (dn_r[DIV_LAT]) begin
      temp_nxt = ntcb_pkg::MIN_CENTI;
    end else if (ovf || q > ntcb_pkg::Q_MAX) begin
      temp_nxt = ntcb_pkg::MAX_CENTI;
    end else begin
      temp_nxt = signed'(TW'(q) - ntcb_pkg::ZERO_C_CENTI);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_r[SL-1].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_r   <= temp_nxt;
      status_r <= side_r[SL-1].status;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = temp_r;
  assign out_status            = status_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled while the output register is empty");

  a_zero_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ntcb_pkg::ST_ZERO) |-> temp_r == ntcb_pkg::MIN_CENTI)
    else $error("zero reading did not give absolute zero");

  a_full_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ntcb_pkg::ST_FULL) |-> temp_r == ntcb_pkg::MAX_CENTI)
    else $error("full-scale reading did not give the upper limit");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (temp_r >= ntcb_pkg::MIN_CENTI && temp_r <= ntcb_pkg::MAX_CENTI))
    else $error("temperature outside the saturation range");

endmodule
`default_nettype wire

>>> bench/tb_ntc_beta_temperature_converter.sv
// Testbench for the NTC beta temperature converter: directed and random requests checked
// against a fixed-point predictor.
`timescale 1ns / 100ps
module tb_ntc_beta_temperature_converter;

  localparam int FULL_SCALE = 4095;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [ntcb_pkg::TEMP_W-1:0] temp;
    logic [1:0] status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] in_adc_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ntcb_pkg::TEMP_W-1:0] out_temperature_centi;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = ntcb_pkg::CFG_SERIES;
  logic [ntcb_pkg::RES_W-1:0] cfg_wdata = '0;

  reading_t expected_readings[$];
  logic [ntcb_pkg::RES_W-1:0] series_ohms = ntcb_pkg::SERIES_RST;
  logic [ntcb_pkg::RES_W-1:0] nominal_ohms = ntcb_pkg::NOMINAL_RST;
  logic [ntcb_pkg::BETA_W-1:0] beta_kelvin = ntcb_pkg::BETA_RST;
  int mismatches = 0;
  int cycles = 0;
  int hold_left = 0;
  int stall_run = 0;
  logic stall_phase = 1'b0;

  ntc_beta_temperature_converter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_adc_sample(in_adc_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_temperature_centi(out_temperature_centi), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned log2_fixed(longint unsigned x);
    int k;
    longint unsigned m;
    longint unsigned frac;
    if (x == 0) x = 1;
    k = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    if (k <= 30) m = x << (30 - k);
    else m = x >> (k - 30);
    frac = 0;
    for (int i = 0; i < ntcb_pkg::LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(k) << ntcb_pkg::LOG_FRAC) | frac;
  endfunction

  function automatic reading_t predict_reading(logic [11:0] sample);
    reading_t rd;
    longint unsigned s, r25, b, la, lb, dmag, lmag, num, q, uden;
    longint lval, den;
    s = (series_ohms == 0) ? 1 : series_ohms;
    r25 = (nominal_ohms == 0) ? 1 : nominal_ohms;
    b = (beta_kelvin == 0) ? 1 : beta_kelvin;
    rd.status = ntcb_pkg::ST_NORMAL;
    if (sample == 0) begin
      rd.temp = ntcb_pkg::MIN_CENTI;
      rd.status = ntcb_pkg::ST_ZERO;
    end else if (sample == FULL_SCALE) begin
      rd.temp = ntcb_pkg::MAX_CENTI;
      rd.status = ntcb_pkg::ST_FULL;
    end else begin
      la = log2_fixed(s * sample);
      lb = log2_fixed(r25 * (FULL_SCALE - sample));
      dmag = (lb > la) ? lb - la : la - lb;
      lmag = (dmag * 64'(ntcb_pkg::LN2_Q28) + (64'd1 << (ntcb_pkg::LOG_FRAC - 1)))
             >> ntcb_pkg::LOG_FRAC;
      lval = (lb > la) ? -longint'(lmag) : longint'(lmag);
      den = longint'((64'd100 * b) << ntcb_pkg::LOG_FRAC)
            + longint'(ntcb_pkg::T25_CENTI) * lval;
      if (den == 0) rd.temp = ntcb_pkg::MAX_CENTI;
      else if (den < 0) rd.temp = ntcb_pkg::MIN_CENTI;
      else begin
        uden = unsigned'(den);
        num = (64'(ntcb_pkg::NUM_SCALE) * b) << ntcb_pkg::LOG_FRAC;
        q = (num + (uden >> 1)) / uden;
        if (q > 64'(ntcb_pkg::Q_MAX)) rd.temp = ntcb_pkg::MAX_CENTI;
        else rd.temp = ntcb_pkg::TEMP_W'(longint'(q) - 27315);
      end
    end
    return rd;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall: random runs, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_run > 0) begin
      out_stall <= stall_phase;
      stall_run <= stall_run - 1;
    end else begin
      stall_phase <= ($urandom_range(0, 99) < 35);
      stall_run <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 4);
      out_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading: temp %0d status %0d",
                                       out_temperature_centi, out_status);
      end else begin
        want = expected_readings.pop_front();
        if (out_temperature_centi !== want.temp || out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
                     want.temp, want.status, out_temperature_centi, out_status);
        end
      end
    end
  end

  task automatic send_sample(logic [11:0] sample, bit allow_gap = 1'b1);
    int gap;
    in_valid <= 1'b1;
    in_adc_sample <= sample;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    expected_readings.push_back(predict_reading(sample));
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_config(logic [ntcb_pkg::RES_W-1:0] s, logic [ntcb_pkg::RES_W-1:0] n,
                            logic [ntcb_pkg::BETA_W-1:0] b);
    cfg_we <= 1'b1;
    cfg_index <= ntcb_pkg::CFG_SERIES;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= ntcb_pkg::CFG_NOMINAL;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_index <= ntcb_pkg::CFG_BETA;
    cfg_wdata <= ntcb_pkg::RES_W'(b);
    @(posedge clk);
    cfg_we <= 1'b0;
    series_ohms = s;
    nominal_ohms = n;
    beta_kelvin = b;
  endtask

  task automatic test_reset_defaults();
    logic [11:0] corners[10] = '{12'd0, 12'd1, 12'd2, 12'd2047, 12'd2048, 12'd4094,
                                 12'd4095, 12'hAAA, 12'h555, 12'd3000};
    foreach (corners[i]) send_sample(corners[i]);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_config(20'd0, 20'hFFFFF, 14'd0);
    send_sample(12'd1);
    send_sample(12'd4094);
    send_sample(12'd2048);
    wait_idle();
    set_config(20'hFFFFF, 20'd1, 14'h3FFF);
    send_sample(12'd1);
    send_sample(12'd4094);
    send_sample(12'd2048);
    wait_idle();
    set_config(20'd1, 20'd1000000, 14'd1000);
    send_sample(12'd1);
    send_sample(12'd4094);
    send_sample(12'd0);
    send_sample(12'd4095);
    wait_idle();
  endtask

  task automatic test_random_settings();
    logic [11:0] sample;
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0) begin
        set_config(ntcb_pkg::SERIES_RST, ntcb_pkg::NOMINAL_RST, ntcb_pkg::BETA_RST);
      end else if (phase == 1) begin
        set_config(20'd1000000, 20'd1, 14'd10000);
      end else begin
        set_config(ntcb_pkg::RES_W'($urandom_range(1, 1000000)),
                   ntcb_pkg::RES_W'($urandom_range(1, 1000000)),
                   ntcb_pkg::BETA_W'($urandom_range(1000, 10000)));
      end
      repeat (200) begin
        case ($urandom_range(0, 9))
          0: sample = 12'($urandom_range(0, 3));
          1: sample = 12'($urandom_range(4092, 4095));
          default: sample = 12'($urandom_range(0, 4095));
        endcase
        send_sample(sample);
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    set_config(ntcb_pkg::RES_W'($urandom_range(1000, 50000)),
               ntcb_pkg::RES_W'($urandom_range(1000, 50000)), 14'd3950);
    @(posedge clk);
    hold_left <= HOLD_CYCLES;
    repeat (200) send_sample(12'($urandom_range(0, 4095)), 1'b0);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
